// ===== rtl/core/mqtc_pkg.sv =====
// Shared types and constants of the multilevel queue time calculator.
// Holds field widths, operation and status codes, beat payloads and the
// controller/datapath command and status structs. No dependencies.
package mqtc_pkg;

  // Table depth default for the top level
  localparam int DEF_MAX_ENTRIES = 16;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int BURST_W  = 16;
  localparam int LEVEL_W  = 2;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 5;
  localparam int TIME_W   = 20;

  localparam int NUM_LEVELS = 3;
  localparam int FIRST_ID   = 1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TERM   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CALC   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // Queue levels walked by a calculate
  localparam logic [LEVEL_W-1:0] LVL_FIRST = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LVL_LAST  = LEVEL_W'(NUM_LEVELS);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Input beat payload
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [BURST_W-1:0] burst_len;
    logic [LEVEL_W-1:0] queue_level;
    logic [TID_W-1:0]   target_id;
  } in_item_t;

  // Result beat payload
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     proc_id;
    logic [TIME_W-1:0]   wait_time;
    logic [TIME_W-1:0]   finish_time;
    logic                last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch input beat, reset scan state
    logic single_op;  // execute create / terminate, load result
    logic next_lvl;   // move scan to next level, slot 0
    logic skip;       // current slot not reported, advance
    logic take;       // current slot reported, advance
    logic finish;     // flush last result of a calculate
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;   // slot index reached entry count
    logic lvl_last;   // walking the lowest level
    logic match;      // current slot is active on the current level
    logic pend_v;     // a reported entry waits in the pending register
    logic out_free;   // output register can take a beat this cycle
  } stat_t;

endpackage

// ===== rtl/core/mqtc_in_if.sv =====
// Input channel of the queue time calculator: valid/ready plus payload.
// Depends on mqtc_pkg.
interface mqtc_in_if;
  import mqtc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mqtc_out_if.sv =====
// Result channel of the queue time calculator: valid/ready plus payload.
// Depends on mqtc_pkg.
interface mqtc_out_if;
  import mqtc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mqtc_ctrl.sv =====
// Controller of the queue time calculator: sequences create, terminate and
// the level-by-level scan of a calculate. Depends on mqtc_pkg.
module mqtc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid_i,
  input  logic [mqtc_pkg::FUNC_W-1:0] in_func_i,
  output logic                      in_ready_o,
  input  mqtc_pkg::stat_t           stat_i,
  output mqtc_pkg::cmd_t            cmd_o
);
  import mqtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_RD,
    S_CHK,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd_o      = '0;
    in_ready_o = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (in_func_i)
            FUNC_CREATE, FUNC_TERM: state_nxt = S_SINGLE;
            FUNC_CALC:              state_nxt = S_RD;
            default:                state_nxt = S_IDLE;  // unused code: dropped
          endcase
        end
      end
      S_SINGLE: begin
        if (stat_i.out_free) begin
          cmd_o.single_op = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      // table read in flight for the current slot
      S_RD: begin
        if (stat_i.scan_end) begin
          if (stat_i.lvl_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd_o.next_lvl = 1'b1;
          end
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat_i.match) begin
          cmd_o.skip = 1'b1;
          state_nxt  = S_RD;
        end else if (!stat_i.pend_v || stat_i.out_free) begin
          cmd_o.take = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/mqtc_dp.sv =====
// Datapath of the queue time calculator: entry table, active bits, scan
// counters, running time sum, pending and output registers.
// Depends on mqtc_pkg; driven by mqtc_ctrl.
module mqtc_dp #(
  parameter int MAX_ENTRIES = mqtc_pkg::DEF_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mqtc_pkg::in_item_t  in_data_i,
  input  mqtc_pkg::cmd_t      cmd_i,
  output mqtc_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  output mqtc_pkg::out_item_t out_data_o,
  input  logic                out_ready_i
);
  import mqtc_pkg::*;

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW  = (TID_W > CW) ? TID_W : CW;
  localparam int ENT_W = BURST_W + LEVEL_W;

  // Entry table: {level, burst}, contents valid only once written
  logic [ENT_W-1:0]       mem_r [MAX_ENTRIES];
  logic [ENT_W-1:0]       rd_q_r;
  logic [MAX_ENTRIES-1:0] active_r;
  logic [CW-1:0]          count_r;

  in_item_t               item_r;
  logic [CW-1:0]          idx_r;
  logic [LEVEL_W-1:0]     lvl_r;
  logic [TIME_W-1:0]      now_r;
  logic                   pend_v_r;
  out_item_t              pend_r;
  logic                   out_v_r, out_v_nxt;
  out_item_t              out_r, out_nxt;
  logic                   load_out;

  logic                   full;
  logic [ID_W-1:0]        new_id;
  logic [TID_W-1:0]       tgt_slot;
  logic                   term_hit;
  logic [LEVEL_W-1:0]     rd_level;
  logic [BURST_W-1:0]     rd_burst;
  logic [TIME_W:0]        fin_sum;
  logic [TIME_W-1:0]      fin_sat;
  logic                   match;
  logic                   do_create, do_term;

  // Create / terminate decode
  assign full      = (count_r == CW'(MAX_ENTRIES));
  assign new_id    = ID_W'({1'b0, count_r} + (CW+1)'(FIRST_ID));
  assign tgt_slot  = item_r.target_id - TID_W'(FIRST_ID);
  assign term_hit  = (item_r.target_id != '0) &&
                     (CMPW'(tgt_slot) < CMPW'(count_r)) &&
                     active_r[tgt_slot[AW-1:0]];
  assign do_create = cmd_i.single_op && (item_r.func == FUNC_CREATE) && !full;
  assign do_term   = cmd_i.single_op && (item_r.func == FUNC_TERM) && term_hit;

  // Scan check on the registered table read
  assign rd_level = rd_q_r[BURST_W +: LEVEL_W];
  assign rd_burst = rd_q_r[BURST_W-1:0];
  assign match    = active_r[idx_r[AW-1:0]] && (rd_level == lvl_r);
  assign fin_sum  = {1'b0, now_r} + (TIME_W+1)'(rd_burst);
  assign fin_sat  = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];

  assign stat_o.scan_end = (idx_r == count_r);
  assign stat_o.lvl_last = (lvl_r == LVL_LAST);
  assign stat_o.match    = match;
  assign stat_o.pend_v   = pend_v_r;
  assign stat_o.out_free = !out_v_r || out_ready_i;

  // Output register load
  always_comb begin
    load_out = 1'b0;
    out_nxt  = out_r;
    if (cmd_i.single_op) begin
      load_out = 1'b1;
      out_nxt  = '{status: ST_OK, proc_id: '0, wait_time: '0,
                   finish_time: '0, last: 1'b1};
      if (item_r.func == FUNC_CREATE) begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.proc_id = new_id;
        end
      end else if (!term_hit) begin
        out_nxt.status = ST_NOT_FOUND;
      end
    end else if (cmd_i.take && pend_v_r) begin
      load_out = 1'b1;
      out_nxt  = pend_r;
    end else if (cmd_i.finish) begin
      load_out = 1'b1;
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_nxt.last = 1'b1;
      end else begin
        out_nxt = '{status: ST_EMPTY, proc_id: '0, wait_time: '0,
                    finish_time: '0, last: 1'b1};
      end
    end
    out_v_nxt = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_v_r);
  end

  // Table memory: write on create, read the scan slot every cycle
  always_ff @(posedge clk) begin
    if (do_create) begin
      mem_r[count_r[AW-1:0]] <= {item_r.queue_level, item_r.burst_len};
    end
    rd_q_r <= mem_r[idx_r[AW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      lvl_r    <= LVL_FIRST;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (do_create) begin
        active_r[count_r[AW-1:0]] <= 1'b1;
        count_r                   <= count_r + CW'(1);
      end
      if (do_term) begin
        active_r[tgt_slot[AW-1:0]] <= 1'b0;
      end
      if (cmd_i.accept) begin
        idx_r    <= '0;
        lvl_r    <= LVL_FIRST;
        pend_v_r <= 1'b0;
      end else if (cmd_i.next_lvl) begin
        idx_r <= '0;
        lvl_r <= lvl_r + LEVEL_W'(1);
      end else if (cmd_i.skip || cmd_i.take) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd_i.take) begin
        pend_v_r <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      item_r <= in_data_i;
      now_r  <= '0;
    end
    if (cmd_i.take) begin
      now_r  <= fin_sat;
      pend_r <= '{status: ST_OK,
                  proc_id: ID_W'({1'b0, idx_r} + (CW+1)'(FIRST_ID)),
                  wait_time: now_r, finish_time: fin_sat, last: 1'b0};
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid_o = out_v_r;
  assign out_data_o  = out_r;

endmodule

// ===== rtl/core/multilevel_queue_time_calc_top.sv =====
// Top level of the multilevel queue time calculator (FCFS per level).
// Depends on mqtc_pkg, mqtc_in_if, mqtc_out_if, mqtc_ctrl and mqtc_dp.
//
//   Channel  Dir  Handshake    Beat contents
//   in_ch    in   valid/ready  func, burst_len, queue_level, target_id
//   out_ch   out  valid/ready  status, proc_id, wait_time, finish_time, last
//
// Create and terminate load their result into the output register from
// the single-op state once that register is free. Calculate reads, then
// checks, each table slot in use, on each level in turn.
// One item is worked at a time; the next is accepted while its last result
// still waits in the output register. A stalled output holds the scan.
// Reset clears the active bits, entry count and control; no clearing pass.
module multilevel_queue_time_calc_top #(
  parameter int MAX_ENTRIES = mqtc_pkg::DEF_MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  mqtc_in_if.sink     in_ch,
  mqtc_out_if.source  out_ch
);
  import mqtc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mqtc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_ch.valid),
    .in_func_i  (in_ch.data.func),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mqtc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data_i   (in_ch.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_ch.valid),
    .out_data_o  (out_ch.data),
    .out_ready_i (out_ch.ready)
  );

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("controller issued more than one command");

  // A taken entry never overwrites a result the sink has not taken
  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && stat.pend_v) |-> stat.out_free)
    else $error("pending result pushed into a busy output register");

  // Error and empty results always close their item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.status != ST_OK) |-> out_ch.data.last)
    else $error("non-ok result without last");

  // Turnaround never below waiting time
  a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.finish_time >= out_ch.data.wait_time))
    else $error("finish time below wait time");

endmodule
